>>> sv/setq_pkg.sv
// Package for the sorted expiry timer queue: opcodes, status codes,
// sequencer states, table entry type and sizing constants. No dependencies.
`default_nettype none
package setq_pkg;

    localparam int TIMER_SLOTS_DEF = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int HANDLE_W        = 16;
    localparam int TIME_W          = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_ADJUST = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_PRESENT   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CK,
        S_DEL_RD,
        S_DEL_WR,
        S_POS_RD,
        S_POS_CK,
        S_INS_RD,
        S_INS_WR,
        S_TICK_RD,
        S_TICK_CK,
        S_TICK_END,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   expiry;
    } entry_t;

endpackage
`default_nettype wire

>>> sv/sorted_expiry_timer_queue.sv
// Sorted expiry timer queue: top level with the entry memory and the sequencer.
// Depends on setq_pkg.
//
//  channel | dir | tdata                           | tuser            | tlast
//  s_*     | in  | [15:0] handle, [47:16] time     | [1:0] op         | -
//  m_*     | out | [1:0] status, [17:2] exp handle | [0] expired_valid| last
//
// One item walks the table in the entry memory; each entry visited takes a
// read issue, then a check or a write back. Add/adjust/delete search, then
// shift and place; a tick scans the expired head entries, then shifts the
// rest down. The memory read port is the limit. Reset clears the count and
// the sequencer state; the table needs no clearing pass. A stalled result
// register holds the sequencer only when it has a further result to give.
`default_nettype none
module sorted_expiry_timer_queue
    import setq_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [15:0] handle, [47:16] time_value
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [1:0] status, [17:2] expired_handle, pad
    output logic [0:0]       m_tuser,   // [0] expired_valid
    output logic             m_tlast
);

    localparam int IDX_W = $clog2(TIMER_SLOTS);
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
    // a tick never reports more than this many timers
    localparam int MAXN  = (MAX_RESULTS < TIMER_SLOTS) ? MAX_RESULTS : TIMER_SLOTS;

    // entry memory, registered read
    entry_t mem [TIMER_SLOTS];
    entry_t rd_data_reg;

    state_t              state_reg, state_next;
    op_t                 op_reg;
    logic [HANDLE_W-1:0] h_reg;
    logic [TIME_W-1:0]   t_reg;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                pend_reg, pend_next;
    logic [HANDLE_W-1:0] pend_h_reg, pend_h_next;
    status_t             status_reg, status_next;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                we;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_data;

    logic                emit;
    status_t             e_status;
    logic                e_valid;
    logic [HANDLE_W-1:0] e_handle;
    logic                e_last;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic                out_expv_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic                out_last_reg;
    logic                out_free;

    logic [CNT_W:0]      idx_p1;
    logic [CNT_W:0]      idx_pn;
    logic                in_acc;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign idx_p1   = {1'b0, idx_reg} + (CNT_W+1)'(1);
    assign idx_pn   = {1'b0, idx_reg} + {1'b0, n_reg};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg <= op_t'(s_tuser);
            h_reg  <= s_tdata[15:0];
            t_reg  <= s_tdata[47:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            slot_reg   <= '0;
            cnt_reg    <= '0;
            n_reg      <= '0;
            pend_reg   <= 1'b0;
            pend_h_reg <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            slot_reg   <= slot_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            pend_reg   <= pend_next;
            pend_h_reg <= pend_h_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        pend_next   = pend_reg;
        pend_h_next = pend_h_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[IDX_W-1:0];
        we          = 1'b0;
        wr_addr     = idx_reg[IDX_W-1:0];
        wr_data     = rd_data_reg;
        emit        = 1'b0;
        e_status    = ST_OK;
        e_valid     = 1'b0;
        e_handle    = '0;
        e_last      = 1'b1;
        s_tready    = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next  = '0;
                    n_next    = '0;
                    pend_next = 1'b0;
                    if (op_t'(s_tuser) == OP_TICK)
                        state_next = S_TICK_RD;
                    else
                        state_next = S_FIND_RD;
                end
            end
            // linear search for the handle
            S_FIND_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (op_reg != OP_ADD)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_RESP;
                    end
                    else if (cnt_reg == CNT_W'(TIMER_SLOTS))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_POS_RD;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_FIND_CK;
                end
            end
            S_FIND_CK:
            begin
                if (rd_data_reg.handle == h_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        status_next = ST_PRESENT;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_DEL_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_p1[CNT_W-1:0];
                    state_next = S_FIND_RD;
                end
            end
            // close the gap left at idx
            S_DEL_RD:
            begin
                if (idx_p1 >= {1'b0, cnt_reg})
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (op_reg == OP_ADJUST)
                    begin
                        idx_next   = '0;
                        state_next = S_POS_RD;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        state_next  = S_RESP;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_p1[IDX_W-1:0];
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                we         = 1'b1;
                idx_next   = idx_p1[CNT_W-1:0];
                state_next = S_DEL_RD;
            end
            // find the insertion point: after every expiry not later than ours
            S_POS_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    slot_next  = idx_reg;
                    idx_next   = cnt_reg;
                    state_next = S_INS_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_POS_CK;
                end
            end
            S_POS_CK:
            begin
                if (rd_data_reg.expiry <= t_reg)
                begin
                    idx_next   = idx_p1[CNT_W-1:0];
                    state_next = S_POS_RD;
                end
                else
                begin
                    slot_next  = idx_reg;
                    idx_next   = cnt_reg;
                    state_next = S_INS_RD;
                end
            end
            // open a hole at slot, top entry first
            S_INS_RD:
            begin
                if (idx_reg == slot_reg)
                begin
                    we          = 1'b1;
                    wr_data     = '{handle: h_reg, expiry: t_reg};
                    cnt_next    = cnt_reg + CNT_W'(1);
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(idx_reg - CNT_W'(1));
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                we         = 1'b1;
                idx_next   = idx_reg - CNT_W'(1);
                state_next = S_INS_RD;
            end
            // scan expired head entries; one result is held back to mark last
            S_TICK_RD:
            begin
                if (idx_reg == cnt_reg || n_reg == CNT_W'(MAXN))
                begin
                    state_next = S_TICK_END;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_TICK_CK;
                end
            end
            S_TICK_CK:
            begin
                if (rd_data_reg.expiry <= t_reg)
                begin
                    if (!pend_reg || out_free)
                    begin
                        emit        = pend_reg;
                        e_valid     = 1'b1;
                        e_handle    = pend_h_reg;
                        e_last      = 1'b0;
                        pend_next   = 1'b1;
                        pend_h_next = rd_data_reg.handle;
                        n_next      = n_reg + CNT_W'(1);
                        idx_next    = idx_p1[CNT_W-1:0];
                        state_next  = S_TICK_RD;
                    end
                end
                else
                begin
                    state_next = S_TICK_END;
                end
            end
            S_TICK_END:
            begin
                if (n_reg == '0)
                begin
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    e_valid    = 1'b1;
                    e_handle   = pend_h_reg;
                    e_last     = 1'b1;
                    pend_next  = 1'b0;
                    idx_next   = '0;
                    state_next = S_SH_RD;
                end
            end
            // drop the n expired entries from the head
            S_SH_RD:
            begin
                if (idx_pn >= {1'b0, cnt_reg})
                begin
                    cnt_next   = cnt_reg - n_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_pn[IDX_W-1:0];
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                we         = 1'b1;
                idx_next   = idx_p1[CNT_W-1:0];
                state_next = S_SH_RD;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_status   = status_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register parts the sequencer from the output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= e_status;
            out_expv_reg   <= e_valid;
            out_handle_reg <= e_handle;
            out_last_reg   <= e_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_handle_reg, out_status_reg};
    assign m_tuser  = out_expv_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

>>> sv/setq_checker.sv
// Port-level checks for the sorted expiry timer queue, bound to the top level.
// Depends on setq_pkg and sorted_expiry_timer_queue.
`default_nettype none
module setq_checker
    import setq_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        m_tlast
);

    // a held result must not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // one item at a time: after an accept the input side closes
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // a plain status result is always the only one of its item
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[17:2] == 16'd0)
        else $error("status result malformed");

    // expired reports always carry status ok
    a_expok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[1:0] == ST_OK)
        else $error("expired report with bad status");

endmodule

bind sorted_expiry_timer_queue setq_checker u_setq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

>>> tb/sorted_expiry_timer_queue_tb.sv
// Testbench for sorted_expiry_timer_queue: drives timer operations on the input stream,
// models the sorted timer table and checks every result item in order.
// Depends on setq_pkg and the sorted_expiry_timer_queue RTL.
`default_nettype none
module sorted_expiry_timer_queue_tb;
    import setq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = TIMER_SLOTS_DEF;
    localparam int CALM_TAIL = 40;

    typedef struct packed {
        op_t         op;
        logic [15:0] handle;
        logic [31:0] tval;
    } timer_op_t;

    typedef struct packed {
        status_t     status;
        logic        exp_valid;
        logic [15:0] exp_handle;
        logic        last;
    } timer_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    sorted_expiry_timer_queue uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Pending operations, expected results and the shadow timer table
    timer_op_t   op_queue[$];
    timer_res_t  expected_results[$];
    logic [15:0] tbl_handle[$];
    logic [31:0] tbl_expiry[$];
    int          errors = 0;
    bit          calm = 1'b0;      // no idling in the closing part
    int          src_gap = 0;
    int          snk_gap = 0;

    task automatic report(input string what);
    begin
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    end
    endtask

    function automatic int find_timer(input logic [15:0] h);
        for (int i = 0; i < tbl_handle.size(); i++)
            if (tbl_handle[i] == h)
                return i;
        return -1;
    endfunction

    // Place after every timer with an equal or earlier expiry
    function automatic void insert_timer(input logic [15:0] h, input logic [31:0] t);
        int pos;
        pos = 0;
        while (pos < tbl_expiry.size() && tbl_expiry[pos] <= t)
            pos++;
        tbl_handle.insert(pos, h);
        tbl_expiry.insert(pos, t);
    endfunction

    function automatic void push_res(input status_t s, input logic v,
                                     input logic [15:0] h, input logic l);
        timer_res_t r;
        r.status = s;
        r.exp_valid = v;
        r.exp_handle = h;
        r.last = l;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_timer_op(input timer_op_t it);
        int slot;
        int n;
        case (it.op)
            OP_ADD:
            begin
                if (find_timer(it.handle) >= 0)
                    push_res(ST_PRESENT, 1'b0, '0, 1'b1);
                else if (tbl_handle.size() >= SLOTS)
                    push_res(ST_FULL, 1'b0, '0, 1'b1);
                else
                begin
                    insert_timer(it.handle, it.tval);
                    push_res(ST_OK, 1'b0, '0, 1'b1);
                end
            end
            OP_ADJUST, OP_DELETE:
            begin
                slot = find_timer(it.handle);
                if (slot < 0)
                    push_res(ST_NOT_FOUND, 1'b0, '0, 1'b1);
                else
                begin
                    tbl_handle.delete(slot);
                    tbl_expiry.delete(slot);
                    if (it.op == OP_ADJUST)
                        insert_timer(it.handle, it.tval);
                    push_res(ST_OK, 1'b0, '0, 1'b1);
                end
            end
            default:
            begin
                n = 0;
                while (n < MAX_RESULTS && tbl_handle.size() > 0 && tbl_expiry[0] <= it.tval)
                begin
                    push_res(ST_OK, 1'b1, tbl_handle[0], 1'b0);
                    void'(tbl_handle.pop_front());
                    void'(tbl_expiry.pop_front());
                    n++;
                end
                if (n == 0)
                    push_res(ST_OK, 1'b0, '0, 1'b1);
                else
                    expected_results[$].last = 1'b1;
            end
        endcase
    endfunction

    // Driver: present items from op_queue with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_timer_op(timer_op_t'({s_tuser, s_tdata[15:0], s_tdata[47:16]}));
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (op_queue.size() > 0)
                begin
                    timer_op_t nx;
                    nx = op_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nx.op;
                    s_tdata <= {nx.tval, nx.handle};
                    if (op_queue.size() < CALM_TAIL)
                        calm <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0)
                        src_gap <= $urandom_range(1, 13);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure and in-order comparison
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report("result item with nothing expected");
                else
                begin
                    timer_res_t e;
                    e = expected_results.pop_front();
                    if (m_tdata[1:0] != e.status)
                        report($sformatf("status %0d, expected %0d", m_tdata[1:0], e.status));
                    if (m_tuser[0] != e.exp_valid)
                        report($sformatf("expired_valid %0b, expected %0b",
                                         m_tuser[0], e.exp_valid));
                    if (m_tdata[17:2] != e.exp_handle)
                        report($sformatf("expired_handle %h, expected %h",
                                         m_tdata[17:2], e.exp_handle));
                    if (m_tlast != e.last)
                        report($sformatf("last %0b, expected %0b", m_tlast, e.last));
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap <= snk_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                snk_gap <= $urandom_range(0, 12);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic void add_op(input op_t o, input logic [15:0] h, input logic [31:0] t);
        timer_op_t it;
        it.op = o;
        it.handle = h;
        it.tval = t;
        op_queue.push_back(it);
    endfunction

    // Random operation biased to live handles so adjust/delete mostly hit
    function automatic void add_random_op(inout logic [15:0] live[$], input logic [31:0] base);
        int sel;
        logic [15:0] h;
        logic [31:0] t;
        sel = $urandom_range(0, 99);
        h = (live.size() > 0 && $urandom_range(0, 3) != 0) ?
            live[$urandom_range(0, live.size() - 1)] : 16'($urandom);
        t = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 400);
        if (sel < 45)
        begin
            if ($urandom_range(0, 4) != 0)
                h = 16'($urandom);
            add_op(OP_ADD, h, t);
            live.push_back(h);
        end
        else if (sel < 65)
            add_op(OP_ADJUST, h, t);
        else if (sel < 75)
            add_op(OP_DELETE, h, t);
        else
            add_op(OP_TICK, 16'($urandom), base + $urandom_range(0, 300));
    endfunction

    initial
    begin
        logic [15:0] live[$];
        logic [31:0] now;
        int waited;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty tick, extremes, duplicates, misses, ties, full table
        add_op(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF);
        add_op(OP_DELETE, 16'h1234, 32'd0);
        add_op(OP_ADJUST, 16'hFFFF, 32'd5);
        add_op(OP_ADD, 16'h0000, 32'd0);
        add_op(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF);
        add_op(OP_ADD, 16'hFFFF, 32'd7);
        add_op(OP_ADD, 16'hA5A5, 32'd100);
        add_op(OP_ADD, 16'h5A5A, 32'd100);
        add_op(OP_ADJUST, 16'hA5A5, 32'd100);
        add_op(OP_ADJUST, 16'hFFFF, 32'd1);
        add_op(OP_DELETE, 16'h0000, 32'hFFFF_FFFF);
        add_op(OP_TICK, 16'd0, 32'd99);
        add_op(OP_TICK, 16'd0, 32'd100);
        for (int i = 0; i < SLOTS; i++)
            add_op(OP_ADD, 16'(16'h0100 + i), 32'(1000 - i % 5));
        add_op(OP_ADD, 16'hBEEF, 32'd3);
        add_op(OP_ADD, 16'h0100, 32'd3);
        add_op(OP_TICK, 16'd0, 32'hFFFF_FFFF);

        // Random part with time moving forward
        now = 32'd2000;
        for (int i = 0; i < 150; i++)
        begin
            add_random_op(live, now);
            now += $urandom_range(0, 60);
            if (live.size() > 64)
                void'(live.pop_front());
        end
        add_op(OP_TICK, 16'd0, 32'hFFFF_FFFF);
        add_op(OP_TICK, 16'd0, 32'hFFFF_FFFF);

        wait (op_queue.size() == 0 && !s_tvalid && expected_results.size() == 0);
        waited = 0;
        while (waited < 400)
        begin
            @(posedge clk);
            waited++;
        end
        if (errors == 0 && expected_results.size() == 0)
            $display("sorted_expiry_timer_queue regression: pass");
        else
            $display("sorted_expiry_timer_queue regression: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("sorted_expiry_timer_queue regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
